// ===== sv/sktup_pkg.sv =====
// ----------------------------------------------------------------------------
// sktup_pkg
// Item, entry and cell-control types shared by the sorted key table.
// ----------------------------------------------------------------------------
package sktup_pkg;

  typedef enum logic [1:0] {
    MODE_UPSERT = 2'd0,
    MODE_PURGE  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_DONE     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] room;
    logic [63:0] guest_name;
    logic [31:0] leave_date;
    logic [4:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  removed_count;
    logic [5:0]  occupancy;
    logic [15:0] entry_room;
    logic [63:0] entry_name;
    logic [31:0] entry_date;
  } out_item_t;

  typedef struct packed {
    logic [15:0] room;
    logic [63:0] name;
    logic [31:0] date;
  } entry_t;

  // Operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_CMP  = 3'd1,
    CELL_UPD  = 3'd2,
    CELL_INS  = 3'd3,
    CELL_SORT = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic        phase;
    entry_t      wr;
    logic [4:0]  position;
  } cell_ctrl_t;

  // Per-cell flags, seen by the neighbours and the controller
  typedef struct packed {
    logic lt;    // key below the upsert key
    logic eq;    // key equal to the upsert key
    logic live;  // entry survives the purge
    logic cnt;   // purge count bit, shifts towards cell 0
  } cell_flags_t;

endpackage

// ===== sv/sktup_cell.sv =====
// ----------------------------------------------------------------------------
// sktup_cell
// One table slot: holds an entry, compares it and trades it with neighbours.
// ----------------------------------------------------------------------------
module sktup_cell
  import sktup_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned FW  = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  logic [FW-1:0] fill_i,
  input  entry_t      prev_entry_i,
  input  cell_flags_t prev_flags_i,
  input  entry_t      next_entry_i,
  input  cell_flags_t next_flags_i,
  output entry_t      entry_o,
  output cell_flags_t flags_o,
  output entry_t      sel_o
);

  localparam logic PAR = 1'(IDX % 2);

  entry_t      entry_q, entry_d;
  cell_flags_t flags_q, flags_d;
  logic        occ;
  logic        boundary;

  assign occ      = FW'(IDX) < fill_i;
  // first slot not below the key: the insert point
  assign boundary = !flags_q.lt && (prev_flags_i.lt || (IDX == 0));

  always_comb begin
    entry_d = entry_q;
    flags_d = flags_q;
    case (ctrl_i.op)
      CELL_CMP: begin
        flags_d.lt   = occ && (entry_q.room < ctrl_i.wr.room);
        flags_d.eq   = occ && (entry_q.room == ctrl_i.wr.room);
        flags_d.live = occ && (entry_q.date != ctrl_i.wr.date);
        flags_d.cnt  = occ && (entry_q.date == ctrl_i.wr.date);
      end
      CELL_UPD: begin
        if (flags_q.eq) begin
          entry_d.name = ctrl_i.wr.name;
          entry_d.date = ctrl_i.wr.date;
        end
      end
      CELL_INS: begin
        if (!flags_q.lt) begin
          entry_d = boundary ? ctrl_i.wr : prev_entry_i;
        end
      end
      CELL_SORT: begin
        // odd-even transposition: a live entry drops below a dead one
        if (PAR == ctrl_i.phase) begin
          if (!flags_q.live && next_flags_i.live) begin
            entry_d      = next_entry_i;
            flags_d.live = 1'b1;
          end
        end else begin
          if (!prev_flags_i.live && flags_q.live) begin
            entry_d      = prev_entry_i;
            flags_d.live = 1'b0;
          end
        end
        flags_d.cnt = next_flags_i.cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign flags_o = flags_q;
  assign sel_o   = ({27'd0, ctrl_i.position} == 32'(IDX)) ? entry_q : '0;

endmodule

// ===== sv/sorted_key_table_upsert_purge.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_upsert_purge
// Table of up to DEPTH entries kept in ascending key order in a row of cells.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one request
//   item: upsert, purge by date, clear or read at a sorted position. Output
//   channel (out_valid_o / out_stall_i / out_item_o) returns one result item
//   per request, in request order.
//   Requests are handled one at a time; in_stall_o is high from acceptance
//   until the result has moved into the output register.
//   Steps from acceptance to out_valid_o with a free output:
//     clear, read : compare, then response
//     upsert      : compare in every cell, insert/update in one go, response
//     purge       : compare, odd-even compaction sweep over the row, response
//   The next request is taken once the result has left the response state.
//   The purge sweep length is set by the row depth: DEPTH transposition
//   rounds, during which the match bits shift into the removal counter.
//   A result waiting on a stalled output is held in the output register; a
//   new request can still be accepted and its result then waits until the
//   output register frees up.
//   Reset empties the table (fill count to zero) and drops any item in
//   flight; slot contents are not cleared and never read while empty.
// ----------------------------------------------------------------------------
module sorted_key_table_upsert_purge
  import sktup_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned FW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_UPS  = 3'd2;
  localparam logic [2:0] ST_SORT = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  logic [2:0]    state_q, state_d;
  in_item_t      item_q, item_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] rm_q, rm_d;     // purge removal counter
  logic [FW-1:0] sw_q, sw_d;     // purge sweep round
  out_item_t     res_q, res_d;
  out_item_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  cell_ctrl_t    ctrl;
  entry_t        ent_v   [DEPTH];
  entry_t        sel_v   [DEPTH];
  cell_flags_t   flags_v [DEPTH];
  logic [DEPTH-1:0] eq_v;
  entry_t        sel_or;
  logic          hit;
  logic          full;
  logic [FW-1:0] rm_sum;
  logic          out_free;

  // --------------------------------------------------------------------------
  // Cell row: cell g trades with g-1 and g+1; ends are tied off so that no
  // exchange or boundary happens beyond the row.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t      prev_e, next_e;
    cell_flags_t prev_f, next_f;

    if (g == 0) begin : g_first
      assign prev_e = '0;
      assign prev_f = '{lt: 1'b0, eq: 1'b0, live: 1'b1, cnt: 1'b0};
    end else begin : g_mid_lo
      assign prev_e = ent_v[g-1];
      assign prev_f = flags_v[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_e = '0;
      assign next_f = '0;
    end else begin : g_mid_hi
      assign next_e = ent_v[g+1];
      assign next_f = flags_v[g+1];
    end

    sktup_cell #(
      .IDX (g),
      .FW  (FW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .fill_i       (fill_q),
      .prev_entry_i (prev_e),
      .prev_flags_i (prev_f),
      .next_entry_i (next_e),
      .next_flags_i (next_f),
      .entry_o      (ent_v[g]),
      .flags_o      (flags_v[g]),
      .sel_o        (sel_v[g])
    );

    assign eq_v[g] = flags_v[g].eq;
  end

  // Read port: each cell drives its entry only when addressed, so an OR
  // gathers the one selected entry.
  always_comb begin
    sel_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_or = entry_t'(sel_or | sel_v[i]);
    end
  end

  // Keys are distinct, so at most one cell reports equality
  assign hit    = |eq_v;
  assign full   = (fill_q == FW'(DEPTH));
  assign rm_sum = rm_q + FW'(flags_v[0].cnt);

  assign out_free = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    fill_d      = fill_q;
    rm_d        = rm_q;
    sw_d        = sw_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    ctrl.op       = CELL_HOLD;
    ctrl.phase    = sw_q[0];
    ctrl.wr.room  = item_q.room;
    ctrl.wr.name  = item_q.guest_name;
    ctrl.wr.date  = item_q.leave_date;
    ctrl.position = item_q.position;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl.op = CELL_CMP;
        res_d   = '0;
        unique case (item_q.mode)
          MODE_UPSERT: begin
            state_d = ST_UPS;
          end
          MODE_PURGE: begin
            rm_d    = '0;
            sw_d    = '0;
            state_d = ST_SORT;
          end
          MODE_CLEAR: begin
            res_d.status        = STAT_DONE;
            res_d.removed_count = 6'(fill_q);
            res_d.occupancy     = '0;
            fill_d              = '0;
            state_d             = ST_RESP;
          end
          MODE_READ: begin
            if (32'(item_q.position) < 32'(fill_q)) begin
              res_d.status     = STAT_DONE;
              res_d.entry_room = sel_or.room;
              res_d.entry_name = sel_or.name;
              res_d.entry_date = sel_or.date;
            end else begin
              res_d.status = STAT_EMPTY;
            end
            res_d.occupancy = 6'(fill_q);
            state_d         = ST_RESP;
          end
          default: ;
        endcase
      end
      ST_UPS: begin
        if (hit) begin
          ctrl.op      = CELL_UPD;
          res_d.status = STAT_UPDATED;
        end else if (full) begin
          res_d.status = STAT_FULL;
        end else begin
          ctrl.op      = CELL_INS;
          fill_d       = fill_q + FW'(1);
          res_d.status = STAT_INSERTED;
        end
        res_d.occupancy = 6'(fill_d);
        state_d         = ST_RESP;
      end
      ST_SORT: begin
        ctrl.op = CELL_SORT;
        rm_d    = rm_sum;
        sw_d    = sw_q + FW'(1);
        if (sw_q == FW'(DEPTH - 1)) begin
          fill_d              = fill_q - rm_sum;
          res_d.status        = STAT_DONE;
          res_d.removed_count = 6'(rm_sum);
          res_d.occupancy     = 6'(fill_d);
          state_d             = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rm_q        <= '0;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rm_q        <= rm_d;
      sw_q        <= sw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(DEPTH))
    else $error("fill count beyond table depth");

  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPS) |-> $onehot0(eq_v))
    else $error("more than one slot matches the key");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPS && !hit && !full) |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("insert did not grow the table");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |-> (sw_q < FW'(DEPTH)))
    else $error("purge sweep overran");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
    else $error("result issued outside the response state");

endmodule

// ===== dv/sorted_key_table_upsert_purge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_upsert_purge_checker
// Watches both channels of the sorted key table, keeps its own copy of the
// table, predicts one outcome per accepted request and compares each result.
// ----------------------------------------------------------------------------
module sorted_key_table_upsert_purge_checker
  import sktup_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  entry_t      rows [DEPTH];
  int unsigned held;
  out_item_t   outcome_q [$];
  int          mismatches = 0;
  int          pending    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;

  // Applies one request to the table copy and returns the result it causes
  function automatic out_item_t predict_outcome(in_item_t req);
    out_item_t   res;
    int unsigned at;
    int unsigned k;
    int unsigned wr;
    res        = '0;
    res.status = STAT_DONE;
    case (mode_e'(req.mode))
      MODE_UPSERT: begin
        at = 0;
        while (at < held && rows[at].room < req.room) at++;
        if (at < held && rows[at].room == req.room) begin
          rows[at].name = req.guest_name;
          rows[at].date = req.leave_date;
          res.status    = STAT_UPDATED;
        end else if (held >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (k = held; k > at; k--) rows[k] = rows[k - 1];
          rows[at] = '{room: req.room, name: req.guest_name, date: req.leave_date};
          held++;
          res.status = STAT_INSERTED;
        end
      end
      MODE_PURGE: begin
        wr = 0;
        for (k = 0; k < held; k++) begin
          if (rows[k].date != req.leave_date) begin
            rows[wr] = rows[k];
            wr++;
          end
        end
        res.removed_count = 6'(held - wr);
        held              = wr;
      end
      MODE_CLEAR: begin
        res.removed_count = 6'(held);
        held              = 0;
      end
      default: begin
        if (req.position < held) begin
          res.entry_room = rows[req.position].room;
          res.entry_name = rows[req.position].name;
          res.entry_date = rows[req.position].date;
        end else begin
          res.status = STAT_EMPTY;
        end
      end
    endcase
    res.occupancy = 6'(held);
    return res;
  endfunction

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_outcome(out_item_t got);
    out_item_t want;
    if (outcome_q.size() == 0) begin
      $error("result item with no request outstanding: 0x%0h", got);
      mismatches++;
      return;
    end
    want = outcome_q.pop_front();
    compare_field("status",        64'(want.status),        64'(got.status));
    compare_field("removed_count", 64'(want.removed_count), 64'(got.removed_count));
    compare_field("occupancy",     64'(want.occupancy),     64'(got.occupancy));
    compare_field("entry_room",    64'(want.entry_room),    64'(got.entry_room));
    compare_field("entry_name",    want.entry_name,         got.entry_name);
    compare_field("entry_date",    64'(want.entry_date),    64'(got.entry_date));
  endtask

  // Result checked before the new request is queued: a result can never
  // belong to a request taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      outcome_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_outcome(out_item_i);
      if (in_valid_i && !in_stall_i) outcome_q.push_back(predict_outcome(in_item_i));
    end
    pending = outcome_q.size();
  end

endmodule

// ===== dv/sorted_key_table_upsert_purge_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_upsert_purge_test
// Drives directed then segmented random request items into the sorted key
// table with random idling on both sides, and reports the checker verdict.
// ----------------------------------------------------------------------------
module sorted_key_table_upsert_purge_test
  import sktup_pkg::*;
();

  localparam int unsigned DEPTH        = 32;
  localparam int          RANDOM_ITEMS = 1725;
  localparam int          KEY_POOL     = 48;
  localparam int          DATE_POOL    = 6;
  // Receiver holds off this long once, so the table's output register fills
  // and the request side stalls while the sender keeps offering.
  localparam int          PRESSURE_AT  = 60;
  localparam int          PRESSURE_LEN = 200;
  // Run limit, far above the longest run; purge is the slowest request
  localparam int          RUN_LIMIT    = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  int        fail_count;
  int        pending;
  int        cycle_count   = 0;
  int        results_taken = 0;
  int        sent_items    = 0;
  bit        steady        = 1'b0;  // no idling on either side while set

  logic [15:0] key_pool  [KEY_POOL];
  logic [31:0] date_pool [DATE_POOL];

  sorted_key_table_upsert_purge #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  sorted_key_table_upsert_purge_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #6 clk_i = ~clk_i;

  // Hard stop should the table ever lock up
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL sorted_key_table_upsert_purge");
      $finish;
    end
  end

  function automatic in_item_t mk_request(mode_e m, logic [15:0] room, logic [63:0] name,
                                          logic [31:0] date, logic [4:0] pos);
    in_item_t req;
    req.mode       = m;
    req.room       = room;
    req.guest_name = name;
    req.leave_date = date;
    req.position   = pos;
    return req;
  endfunction

  // Random request. Keys and dates mostly come from small pools so that
  // updates, full-table refusals and purges that hit are all common. A
  // growing segment only upserts and reads, to drive the table to full.
  function automatic in_item_t draw_request(bit grow);
    in_item_t req;
    int       roll;
    roll           = $urandom_range(0, 99);
    req.guest_name = {$urandom, $urandom};
    req.room       = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                                : 16'($urandom);
    req.leave_date = ($urandom_range(0, 3) != 0) ? date_pool[$urandom_range(0, DATE_POOL - 1)]
                                                 : $urandom;
    req.position   = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    if (grow)
      req.mode = (roll < 85) ? MODE_UPSERT : MODE_READ;
    else if (roll < 55)
      req.mode = MODE_UPSERT;
    else if (roll < 70)
      req.mode = MODE_PURGE;
    else if (roll < 73)
      req.mode = MODE_CLEAR;
    else
      req.mode = MODE_READ;
    return req;
  endfunction

  // Valid is only dropped when a gap follows, so a back-to-back item never
  // sees valid lowered and raised in the same step.
  task automatic send_request(in_item_t req);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_items++;
  endtask

  // Result side: a random hold before each item, plus one long hold-off
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (results_taken == PRESSURE_AT) hold = PRESSURE_LEN;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      results_taken++;
    end
  end

  initial begin : stimulus
    int seg_len;
    bit grow;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;

    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = 16'($urandom);
    date_pool[0] = 32'h0000_0000;
    date_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < DATE_POOL; i++) date_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table first, then key and field extremes, update of a
    // held key, reads in and past the held range, purges and clear.
    send_request(mk_request(MODE_READ,   16'h1234, '1, '1, 5'd0));
    send_request(mk_request(MODE_PURGE,  16'h0000, '0, 32'h0, 5'd31));
    send_request(mk_request(MODE_CLEAR,  16'hFFFF, '1, '1, 5'd31));
    send_request(mk_request(MODE_UPSERT, 16'h8000, '1, 32'hFFFF_FFFF, 5'd0));
    send_request(mk_request(MODE_UPSERT, 16'h0000, '0, 32'h0, 5'd31));
    send_request(mk_request(MODE_UPSERT, 16'hFFFF, 64'hA5A5_5A5A_0F0F_F0F0, 32'd1, 5'd0));
    send_request(mk_request(MODE_UPSERT, 16'h4000, 64'h0123_4567_89AB_CDEF, 32'd1, 5'd0));
    send_request(mk_request(MODE_UPSERT, 16'h8000, 64'hFEDC_BA98_7654_3210, 32'h0, 5'd0));
    send_request(mk_request(MODE_READ,   16'h0, '0, '0, 5'd0));
    send_request(mk_request(MODE_READ,   16'h0, '0, '0, 5'd1));
    send_request(mk_request(MODE_READ,   16'h0, '0, '0, 5'd2));
    send_request(mk_request(MODE_READ,   16'h0, '0, '0, 5'd3));
    send_request(mk_request(MODE_READ,   16'h0, '0, '0, 5'd4));
    send_request(mk_request(MODE_READ,   16'h0, '0, '0, 5'd31));
    send_request(mk_request(MODE_PURGE,  16'h0, '0, 32'h0, 5'd0));
    send_request(mk_request(MODE_READ,   16'h0, '0, '0, 5'd0));
    send_request(mk_request(MODE_PURGE,  16'h0, '0, 32'h5555_AAAA, 5'd0));
    send_request(mk_request(MODE_PURGE,  16'h0, '0, 32'd1, 5'd0));
    send_request(mk_request(MODE_UPSERT, 16'h0001, 64'h1, 32'hFFFF_FFFF, 5'd0));
    send_request(mk_request(MODE_UPSERT, 16'hFFFE, 64'h2, 32'hFFFF_FFFF, 5'd0));
    send_request(mk_request(MODE_PURGE,  16'h0, '0, 32'hFFFF_FFFF, 5'd0));
    send_request(mk_request(MODE_UPSERT, 16'h7FFF, '1, 32'h8000_0000, 5'd0));
    send_request(mk_request(MODE_CLEAR,  16'h0, '0, '0, 5'd0));
    send_request(mk_request(MODE_READ,   16'h0, '0, '0, 5'd0));

    // Random segments: growing stretches fill the table to the brim,
    // mixed ones purge, clear and read it back down.
    while (sent_items < RANDOM_ITEMS + 24) begin
      seg_len = $urandom_range(30, 80);
      grow    = ($urandom_range(0, 2) == 0);
      steady  = ($urandom_range(0, 4) == 0);
      repeat (seg_len) send_request(draw_request(grow));
    end
    in_valid_i <= 1'b0;
    steady     = 1'b0;

    // Drain, then allow a full purge sweep for any stray result
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4 * DEPTH) @(posedge clk_i);
    if (fail_count == 0)
      $display("PASS sorted_key_table_upsert_purge");
    else
      $display("FAIL sorted_key_table_upsert_purge");
    $finish;
  end

endmodule
